/* rtl/btd_pkg.sv */
// Shared types, constants and decode helpers for the byte-level text decoder.
// Used by btd_front, btd_queue, btd_back and the top level.
package btd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] QMARK = 8'h3F;

    // One queued request: up to four raw bytes, lowest index first
    typedef struct packed {
        logic            last;
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } t_entry;

    // Bytes produced by one codepoint
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } t_map;

    // Sequence length started by a lead byte, 0 for a bad lead
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] n;
        if (!c[7]) begin
            n = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (c[7:3] == 5'b11110) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    // Byte-level table lookup, UTF-8 re-encode for codepoints outside it
    function automatic t_map map_cp(input logic [20:0] cp);
        t_map       m;
        logic [6:0] k;
        m = '0;
        k = cp[6:0];
        if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
            (cp >= 21'd174 && cp <= 21'd255)) begin
            m.len  = 3'd1;
            m.b[0] = cp[7:0];
        end else if (cp >= 21'd256 && cp <= 21'd323) begin
            m.len = 3'd1;
            if (k <= 7'd32) begin
                m.b[0] = {1'b0, k};
            end else if (k <= 7'd66) begin
                m.b[0] = {1'b0, k} + 8'd94;
            end else begin
                m.b[0] = 8'd173;
            end
        end else if (cp <= 21'h7F) begin
            m.len  = 3'd1;
            m.b[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            m.len  = 3'd2;
            m.b[0] = {3'b110, cp[10:6]};
            m.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            m.len  = 3'd3;
            m.b[0] = {4'b1110, cp[15:12]};
            m.b[1] = {2'b10, cp[11:6]};
            m.b[2] = {2'b10, cp[5:0]};
        end else begin
            m.len  = 3'd4;
            m.b[0] = {5'b11110, cp[20:18]};
            m.b[1] = {2'b10, cp[17:12]};
            m.b[2] = {2'b10, cp[11:6]};
            m.b[3] = {2'b10, cp[5:0]};
        end
        return m;
    endfunction

endpackage

/* rtl/btd_front.sv */
// Front end: accepts raw text bytes, holds an unfinished UTF-8 prefix and
// hands complete (or flushed) groups to the queue. Depends on btd_pkg.
module btd_front import btd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_room,
    output logic       o_ready,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [2:0][7:0] r_pend;
    logic [1:0]      r_pcnt;
    logic [3:0][7:0] n_buf;
    logic [2:0]      n_cnt;
    logic [7:0]      w_lead;
    logic [2:0]      w_len;
    logic            w_hold;
    logic            w_acc;

    // Join held bytes with the new one
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i < int'(r_pcnt)) begin
                n_buf[i] = r_pend[i];
            end else if (i == int'(r_pcnt)) begin
                n_buf[i] = i_byte;
            end else begin
                n_buf[i] = '0;
            end
        end
        n_cnt  = {1'b0, r_pcnt} + 3'd1;
        w_lead = n_buf[0];
        w_len  = seq_len(w_lead);
        w_hold = !i_last && (w_len != 3'd0) && (w_len > n_cnt);
    end

    assign o_ready       = i_room;
    assign w_acc         = i_valid && i_room;
    assign o_push        = w_acc && !w_hold;
    assign o_entry.last  = i_last;
    assign o_entry.cnt   = n_cnt;
    assign o_entry.bytes = n_buf;

    // Pending prefix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
        end else if (w_acc) begin
            r_pcnt <= w_hold ? n_cnt[1:0] : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend <= n_buf[2:0];
        end
    end

    // A held prefix always starts with a lead that needs more bytes
    a_pend_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt != 2'd0) |-> (seq_len(r_pend[0]) > {1'b0, r_pcnt}))
        else $error("held prefix does not start with an open lead");

endmodule

/* rtl/btd_queue.sv */
// Short request queue between front and back end, register based.
// Depends on btd_pkg.
module btd_queue import btd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_room,
    output logic   o_valid,
    output t_entry o_head
);

    t_entry          r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QAW:0]    r_cnt;

    assign o_room  = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_room || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

/* rtl/btd_back.sv */
// Back end: walks one queued group a sequence at a time, maps each codepoint
// and streams the bytes into the output register. Depends on btd_pkg.
module btd_back import btd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_run_last,
    output logic       o_text_end
);

    logic [1:0]  r_pos;
    logic [1:0]  r_idx;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_orun;
    logic        r_oend;

    logic [7:0]  w_c;
    logic [7:0]  w_b1;
    logic [7:0]  w_b2;
    logic [7:0]  w_b3;
    logic [2:0]  w_n;
    logic [2:0]  w_avail;
    logic        w_trunc;
    logic [20:0] w_cp;
    t_map        w_map;
    logic [2:0]  w_used;
    logic        w_seq_done;
    logic        w_ent_done;
    logic        w_load;

    // Decode the sequence at the current position
    always_comb begin
        w_c     = i_head.bytes[r_pos];
        w_b1    = i_head.bytes[r_pos + 2'd1];
        w_b2    = i_head.bytes[r_pos + 2'd2];
        w_b3    = i_head.bytes[r_pos + 2'd3];
        w_n     = seq_len(w_c);
        w_avail = i_head.cnt - {1'b0, r_pos};
        w_trunc = (w_n == 3'd0) || (w_n > w_avail);
        case (w_n)
            3'd2:    w_cp = {10'd0, w_c[4:0], w_b1[5:0]};
            3'd3:    w_cp = {5'd0, w_c[3:0], w_b1[5:0], w_b2[5:0]};
            3'd4:    w_cp = {w_c[2:0], w_b1[5:0], w_b2[5:0], w_b3[5:0]};
            default: w_cp = {13'd0, w_c};
        endcase
        if (w_trunc) begin
            w_map      = '0;
            w_map.len  = 3'd1;
            w_map.b[0] = QMARK;
            w_used     = 3'd1;
        end else begin
            w_map  = map_cp(w_cp);
            w_used = w_n;
        end
        w_seq_done = ({1'b0, r_idx} == (w_map.len - 3'd1));
        w_ent_done = w_seq_done && (({1'b0, r_pos} + w_used) == i_head.cnt);
    end

    assign w_load = i_valid && (!r_ovalid || i_ready);
    assign o_pop  = w_load && w_ent_done;

    // Position within the group and byte index within the sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
        end else if (w_load) begin
            if (w_ent_done) begin
                r_pos <= '0;
                r_idx <= '0;
            end else if (w_seq_done) begin
                r_pos <= r_pos + w_used[1:0];
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_obyte <= w_map.b[r_idx];
            r_orun  <= w_ent_done;
            r_oend  <= w_ent_done && i_head.last;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_byte     = r_obyte;
    assign o_run_last = r_orun;
    assign o_text_end = r_oend;

    a_pos_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ({1'b0, r_pos} < i_head.cnt))
        else $error("position past end of group");
    a_idx_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ({1'b0, r_idx} < w_map.len))
        else $error("byte index past end of sequence");
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend) |-> r_orun)
        else $error("text end without run end");

endmodule

/* rtl/byte_level_text_decoder.sv */
// Byte-level text decoder: lenient UTF-8 decode plus byte-level table map.
// Top level; instantiates btd_front, btd_queue and btd_back from btd_pkg.
//
// Raw bytes of a joined token string enter one per cycle while the queue has
// room. A byte that only extends an unfinished UTF-8 sequence is absorbed
// with no output; otherwise the group of bytes goes into a four-entry queue
// and the back end emits the decoded bytes at one per cycle while the output
// is ready. An input that yields k output bytes (at most four) holds the back
// end until all are out, so the sustained rate is one input per cycle as long
// as each input yields at most one byte; the queue absorbs short bursts of
// multi-byte results. tlast marks the final output byte of the text, tuser
// the last byte of one input. No clearing pass; ready once reset is released.
module byte_level_text_decoder import btd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  logic       i_s_tlast,   // text_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tuser,   // [0] run_last
    output logic       o_m_tlast    // text_end
);

    logic   w_room;
    logic   w_push;
    t_entry w_entry;
    logic   w_qvalid;
    t_entry w_head;
    logic   w_pop;

    btd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_room  (w_room),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    btd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (w_qvalid),
        .o_head  (w_head)
    );

    btd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_qvalid),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_byte     (o_m_tdata),
        .o_run_last (o_m_tuser),
        .o_text_end (o_m_tlast)
    );

endmodule
